>>> rtl/core/afcm_pkg.sv
`default_nettype none

package afcm_pkg;

    // Number of stored frustum planes.
    localparam int NUM_PLANES = 6;
    localparam int PLANE_W    = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    // Field widths.
    localparam int MODE_W   = 2;
    localparam int PIDX_W   = 3;
    localparam int NORM_W   = 18;
    localparam int COORD_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int NAXES    = 3;
    localparam int AXIS_W   = 2;

    // Exact product and sum widths: an 18 by 32 product, and three of them
    // plus the offset scaled up by the fraction width.
    localparam int PROD_W = NORM_W + COORD_W;
    localparam int OFFS_W = COORD_W + FRAC_W;
    localparam int ACC_W  = PROD_W + 2;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BOX     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOX_END = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_MERGE
    } t_state;

    // One stored plane.
    typedef struct packed {
        logic signed [NORM_W-1:0]  normal_x;
        logic signed [NORM_W-1:0]  normal_y;
        logic signed [NORM_W-1:0]  normal_z;
        logic signed [COORD_W-1:0] offset;
    } t_plane;

    // Control that travels with each term into the multiply-accumulate unit.
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

`default_nettype wire

>>> rtl/core/afcm_mac.sv
`default_nettype none

module afcm_mac (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_clear,
    input  wire afcm_pkg::t_mac_ctl                 i_ctl,
    input  wire signed [afcm_pkg::NORM_W-1:0]       i_normal,
    input  wire signed [afcm_pkg::COORD_W-1:0]      i_coord,
    input  wire signed [afcm_pkg::COORD_W-1:0]      i_offset,
    output logic                                    o_culled
);

    logic signed [afcm_pkg::PROD_W-1:0]  n_prod;
    logic signed [afcm_pkg::PROD_W-1:0]  r_prod;
    logic signed [afcm_pkg::COORD_W-1:0] r_off;
    afcm_pkg::t_mac_ctl                  r_ctl;
    logic signed [afcm_pkg::ACC_W-1:0]   r_acc;
    logic signed [afcm_pkg::ACC_W-1:0]   n_acc;
    logic signed [afcm_pkg::OFFS_W-1:0]  off_sh;
    logic                                r_culled;

    // First stage: one exact signed product per cycle.
    assign n_prod = afcm_pkg::PROD_W'(i_normal) * afcm_pkg::PROD_W'(i_coord);

    // Second stage: a plane's sum starts from its scaled offset.
    assign off_sh = {r_off, {afcm_pkg::FRAC_W{1'b0}}};
    assign n_acc  = (r_ctl.first ? afcm_pkg::ACC_W'(off_sh) : r_acc)
                  + afcm_pkg::ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl    <= '0;
            r_culled <= 1'b0;
        end else begin
            r_ctl <= i_ctl;
            if (i_clear) begin
                r_culled <= 1'b0;
            end else if (r_ctl.vld && r_ctl.last
                         && !n_acc[afcm_pkg::ACC_W-1] && (n_acc != '0)) begin
                // The picked corner lies strictly outside this plane.
                r_culled <= 1'b1;
            end
        end
    end

    // Payload of the pipeline needs no reset.
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_off  <= i_offset;
        if (r_ctl.vld) begin
            r_acc <= n_acc;
        end
    end

    assign o_culled = r_culled;

endmodule

`default_nettype wire

>>> rtl/core/aabb_frustum_cull_merge_top.sv
`default_nettype none

// Frustum culling of axis-aligned boxes with a running merge of the visible
// ones. A load word (mode 0) writes one of the NUM_PLANES stored planes and
// gives no result; a load to a slot beyond the last plane and a word of
// mode 3 are dropped. A box word (mode 1, or mode 2 to end the set) is
// tested against every stored plane by one shared 18 by 32 multiplier that
// takes one axis of one plane per cycle; the block then drains the
// multiplier, waits until the output register is free, and takes no new
// word until the box is finished. Its result then sits in the output
// register while the next word is accepted. Every box gives one result word
// with its own visibility, the merged bounds of the set so far (zero while
// no box is visible) and a set-end flag; the set-end box clears the merge
// after its result. Planes must be loaded before boxes are sent.
module aabb_frustum_cull_merge_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,

    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire [afcm_pkg::MODE_W-1:0]          i_mode,
    input  wire [afcm_pkg::PIDX_W-1:0]          i_plane_index,
    input  wire signed [afcm_pkg::NORM_W-1:0]   i_normal_x,
    input  wire signed [afcm_pkg::NORM_W-1:0]   i_normal_y,
    input  wire signed [afcm_pkg::NORM_W-1:0]   i_normal_z,
    input  wire signed [afcm_pkg::COORD_W-1:0]  i_plane_offset,
    input  wire signed [afcm_pkg::COORD_W-1:0]  i_low_x,
    input  wire signed [afcm_pkg::COORD_W-1:0]  i_low_y,
    input  wire signed [afcm_pkg::COORD_W-1:0]  i_low_z,
    input  wire signed [afcm_pkg::COORD_W-1:0]  i_high_x,
    input  wire signed [afcm_pkg::COORD_W-1:0]  i_high_y,
    input  wire signed [afcm_pkg::COORD_W-1:0]  i_high_z,

    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic                                o_box_visible,
    output logic                                o_any_visible,
    output logic                                o_set_done,
    output logic signed [afcm_pkg::COORD_W-1:0] o_merged_low_x,
    output logic signed [afcm_pkg::COORD_W-1:0] o_merged_low_y,
    output logic signed [afcm_pkg::COORD_W-1:0] o_merged_low_z,
    output logic signed [afcm_pkg::COORD_W-1:0] o_merged_high_x,
    output logic signed [afcm_pkg::COORD_W-1:0] o_merged_high_y,
    output logic signed [afcm_pkg::COORD_W-1:0] o_merged_high_z
);

    afcm_pkg::t_state                    r_state;
    afcm_pkg::t_state                    n_state;
    logic [afcm_pkg::PLANE_W-1:0]        r_plane;
    logic [afcm_pkg::AXIS_W-1:0]         r_axis;
    afcm_pkg::t_plane                    r_planes [afcm_pkg::NUM_PLANES];
    afcm_pkg::t_plane                    cur_plane;
    logic signed [afcm_pkg::COORD_W-1:0] r_lo [afcm_pkg::NAXES];
    logic signed [afcm_pkg::COORD_W-1:0] r_hi [afcm_pkg::NAXES];
    logic                                r_end;
    logic signed [afcm_pkg::COORD_W-1:0] r_mlo [afcm_pkg::NAXES];
    logic signed [afcm_pkg::COORD_W-1:0] r_mhi [afcm_pkg::NAXES];
    logic signed [afcm_pkg::COORD_W-1:0] n_mlo [afcm_pkg::NAXES];
    logic signed [afcm_pkg::COORD_W-1:0] n_mhi [afcm_pkg::NAXES];
    logic                                r_found;
    logic                                n_found;
    logic                                r_out_valid;
    logic                                r_out_vis;
    logic                                r_out_any;
    logic                                r_out_done;
    logic signed [afcm_pkg::COORD_W-1:0] r_out_lo [afcm_pkg::NAXES];
    logic signed [afcm_pkg::COORD_W-1:0] r_out_hi [afcm_pkg::NAXES];

    logic                                in_fire;
    logic                                is_box;
    logic                                load_ok;
    logic                                last_issue;
    logic                                slot_free;
    logic                                do_merge;
    logic                                vis;
    logic                                culled;
    afcm_pkg::t_mac_ctl                  mac_ctl;
    logic signed [afcm_pkg::NORM_W-1:0]  sel_normal;
    logic signed [afcm_pkg::COORD_W-1:0] sel_coord;

    // Word acceptance and decode.
    assign in_fire = i_in_valid && o_in_ready;
    assign is_box  = (i_mode == afcm_pkg::MODE_BOX) || (i_mode == afcm_pkg::MODE_BOX_END);
    assign load_ok = (i_mode == afcm_pkg::MODE_LOAD)
                  && ({1'b0, i_plane_index} < 4'(afcm_pkg::NUM_PLANES));

    assign last_issue = (r_axis == afcm_pkg::AXIS_W'(afcm_pkg::NAXES - 1))
                     && (r_plane == afcm_pkg::PLANE_W'(afcm_pkg::NUM_PLANES - 1));
    assign slot_free  = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            afcm_pkg::ST_IDLE: begin
                if (in_fire && is_box) begin
                    n_state = afcm_pkg::ST_MUL;
                end
            end
            afcm_pkg::ST_MUL: begin
                if (last_issue) begin
                    n_state = afcm_pkg::ST_DRAIN;
                end
            end
            afcm_pkg::ST_DRAIN: begin
                n_state = afcm_pkg::ST_MERGE;
            end
            afcm_pkg::ST_MERGE: begin
                if (slot_free) begin
                    n_state = afcm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = afcm_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_ready    = 1'b0;
        mac_ctl.vld   = 1'b0;
        mac_ctl.first = (r_axis == '0);
        mac_ctl.last  = (r_axis == afcm_pkg::AXIS_W'(afcm_pkg::NAXES - 1));
        do_merge      = 1'b0;
        unique case (r_state)
            afcm_pkg::ST_IDLE:  o_in_ready  = 1'b1;
            afcm_pkg::ST_MUL:   mac_ctl.vld = 1'b1;
            afcm_pkg::ST_DRAIN: mac_ctl.vld = 1'b0;
            afcm_pkg::ST_MERGE: do_merge    = slot_free;
            default:            o_in_ready  = 1'b0;
        endcase
    end

    // Operand selection: the corner on the negative side of the normal.
    assign cur_plane = r_planes[r_plane];
    always_comb begin
        unique case (r_axis)
            2'd0:    sel_normal = cur_plane.normal_x;
            2'd1:    sel_normal = cur_plane.normal_y;
            default: sel_normal = cur_plane.normal_z;
        endcase
    end
    always_comb begin
        unique case (r_axis)
            2'd0:    sel_coord = sel_normal[afcm_pkg::NORM_W-1] ? r_hi[0] : r_lo[0];
            2'd1:    sel_coord = sel_normal[afcm_pkg::NORM_W-1] ? r_hi[1] : r_lo[1];
            default: sel_coord = sel_normal[afcm_pkg::NORM_W-1] ? r_hi[2] : r_lo[2];
        endcase
    end

    afcm_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (in_fire),
        .i_ctl    (mac_ctl),
        .i_normal (sel_normal),
        .i_coord  (sel_coord),
        .i_offset (cur_plane.offset),
        .o_culled (culled)
    );

    // Merge: the first visible box starts the bounds, later ones widen them.
    assign vis     = !culled;
    assign n_found = r_found || vis;
    always_comb begin
        for (int a = 0; a < afcm_pkg::NAXES; a++) begin
            n_mlo[a] = r_mlo[a];
            n_mhi[a] = r_mhi[a];
            if (vis) begin
                if (!r_found || (r_lo[a] < r_mlo[a])) begin
                    n_mlo[a] = r_lo[a];
                end
                if (!r_found || (r_hi[a] > r_mhi[a])) begin
                    n_mhi[a] = r_hi[a];
                end
            end
        end
    end

    // Control registers and merge state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= afcm_pkg::ST_IDLE;
            r_plane     <= '0;
            r_axis      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int a = 0; a < afcm_pkg::NAXES; a++) begin
                r_mlo[a] <= '0;
                r_mhi[a] <= '0;
            end
        end else begin
            r_state <= n_state;

            // Plane and axis counters step through every term of the box.
            if (in_fire) begin
                r_plane <= '0;
                r_axis  <= '0;
            end else if (r_state == afcm_pkg::ST_MUL) begin
                if (r_axis == afcm_pkg::AXIS_W'(afcm_pkg::NAXES - 1)) begin
                    r_axis  <= '0;
                    r_plane <= r_plane + 1'b1;
                end else begin
                    r_axis <= r_axis + 1'b1;
                end
            end

            if (do_merge) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // The set-end box clears the merge after its result is formed.
            if (do_merge) begin
                r_found <= r_end ? 1'b0 : n_found;
                for (int a = 0; a < afcm_pkg::NAXES; a++) begin
                    r_mlo[a] <= r_end ? '0 : n_mlo[a];
                    r_mhi[a] <= r_end ? '0 : n_mhi[a];
                end
            end
        end
    end

    // Payload registers: plane store, captured box and result word.
    always_ff @(posedge i_clk) begin
        if (in_fire && load_ok) begin
            r_planes[i_plane_index[afcm_pkg::PLANE_W-1:0]] <=
                '{normal_x: i_normal_x, normal_y: i_normal_y,
                  normal_z: i_normal_z, offset: i_plane_offset};
        end
        if (in_fire && is_box) begin
            r_lo[0] <= i_low_x;
            r_lo[1] <= i_low_y;
            r_lo[2] <= i_low_z;
            r_hi[0] <= i_high_x;
            r_hi[1] <= i_high_y;
            r_hi[2] <= i_high_z;
            r_end   <= (i_mode == afcm_pkg::MODE_BOX_END);
        end
        if (do_merge) begin
            r_out_vis  <= vis;
            r_out_any  <= n_found;
            r_out_done <= r_end;
            for (int a = 0; a < afcm_pkg::NAXES; a++) begin
                r_out_lo[a] <= n_mlo[a];
                r_out_hi[a] <= n_mhi[a];
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_box_visible   = r_out_vis;
    assign o_any_visible   = r_out_any;
    assign o_set_done      = r_out_done;
    assign o_merged_low_x  = r_out_lo[0];
    assign o_merged_low_y  = r_out_lo[1];
    assign o_merged_low_z  = r_out_lo[2];
    assign o_merged_high_x = r_out_hi[0];
    assign o_merged_high_y = r_out_hi[1];
    assign o_merged_high_z = r_out_hi[2];

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;

    import afcm_pkg::*;

    localparam int ITEM_TARGET  = 450;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int ONE          = 65536;

    // Mode 3 has no meaning to the block and must be dropped.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [NORM_W-1:0]  NORM_MIN  = {1'b1, {(NORM_W-1){1'b0}}};
    localparam logic signed [NORM_W-1:0]  NORM_MAX  = {1'b0, {(NORM_W-1){1'b1}}};

    // One input word and one result word, field by field.
    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic [PIDX_W-1:0]          plane_index;
        logic signed [NORM_W-1:0]   normal_x;
        logic signed [NORM_W-1:0]   normal_y;
        logic signed [NORM_W-1:0]   normal_z;
        logic signed [COORD_W-1:0]  plane_offset;
        logic signed [COORD_W-1:0]  low_x;
        logic signed [COORD_W-1:0]  low_y;
        logic signed [COORD_W-1:0]  low_z;
        logic signed [COORD_W-1:0]  high_x;
        logic signed [COORD_W-1:0]  high_y;
        logic signed [COORD_W-1:0]  high_z;
    } t_cull_word;

    typedef struct packed {
        logic                       box_visible;
        logic                       any_visible;
        logic                       set_done;
        logic signed [COORD_W-1:0]  merged_low_x;
        logic signed [COORD_W-1:0]  merged_low_y;
        logic signed [COORD_W-1:0]  merged_low_z;
        logic signed [COORD_W-1:0]  merged_high_x;
        logic signed [COORD_W-1:0]  merged_high_y;
        logic signed [COORD_W-1:0]  merged_high_z;
    } t_cull_result;

    typedef enum {RX_OPEN, RX_COIN, RX_SLOW, RX_BEAT} t_rx_mode;

    // Keeps its own copy of the planes and the running merge, and the results
    // that the accepted box words must produce, oldest first.
    class cull_scoreboard;
        logic signed [NORM_W-1:0]  plane_nrm [NUM_PLANES][NAXES];
        logic signed [COORD_W-1:0] plane_off [NUM_PLANES];
        logic signed [COORD_W-1:0] mrg_lo [NAXES];
        logic signed [COORD_W-1:0] mrg_hi [NAXES];
        bit                        found;
        t_cull_result              pending [$];
        int errors, checked, boxes, visible, sets, loads, dropped;

        function new();
            for (int p = 0; p < NUM_PLANES; p++) begin
                plane_off[p] = '0;
                for (int a = 0; a < NAXES; a++) plane_nrm[p][a] = '0;
            end
            for (int a = 0; a < NAXES; a++) begin
                mrg_lo[a] = '0;
                mrg_hi[a] = '0;
            end
            found = 1'b0;
        endfunction

        function int waiting();
            return pending.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50) $display("[cull] mismatch: %s", msg);
        endtask

        task check_field(string name, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
            if (got !== want)
                report($sformatf("result %0d %s got %0d want %0d",
                                 checked, name, $signed(got), $signed(want)));
        endtask

        // Applies one accepted word to the plane store and the merge.
        function void note_word(t_cull_word w);
            logic signed [COORD_W-1:0] lo [NAXES];
            logic signed [COORD_W-1:0] hi [NAXES];
            logic signed [COORD_W-1:0] corner;
            t_cull_result              r;
            longint                    acc;
            bit                        vis;
            lo[0] = w.low_x;  lo[1] = w.low_y;  lo[2] = w.low_z;
            hi[0] = w.high_x; hi[1] = w.high_y; hi[2] = w.high_z;
            case (w.mode)
                MODE_LOAD: begin
                    if (w.plane_index < NUM_PLANES) begin
                        plane_nrm[w.plane_index][0] = w.normal_x;
                        plane_nrm[w.plane_index][1] = w.normal_y;
                        plane_nrm[w.plane_index][2] = w.normal_z;
                        plane_off[w.plane_index]    = w.plane_offset;
                        loads++;
                    end else begin
                        dropped++;
                    end
                end
                MODE_BOX, MODE_BOX_END: begin
                    // The corner on the negative side of each normal decides;
                    // a sum strictly above zero culls the box.
                    vis = 1'b1;
                    for (int p = 0; p < NUM_PLANES; p++) begin
                        acc = longint'(plane_off[p]) * 64'sd65536;
                        for (int a = 0; a < NAXES; a++) begin
                            corner = (plane_nrm[p][a] >= 0) ? lo[a] : hi[a];
                            acc += longint'(plane_nrm[p][a]) * longint'(corner);
                        end
                        if (acc > 0) vis = 1'b0;
                    end
                    boxes++;
                    if (vis) begin
                        visible++;
                        for (int a = 0; a < NAXES; a++) begin
                            if (!found || lo[a] < mrg_lo[a]) mrg_lo[a] = lo[a];
                            if (!found || hi[a] > mrg_hi[a]) mrg_hi[a] = hi[a];
                        end
                        found = 1'b1;
                    end
                    r.box_visible   = vis;
                    r.any_visible   = found;
                    r.set_done      = (w.mode == MODE_BOX_END);
                    r.merged_low_x  = found ? mrg_lo[0] : '0;
                    r.merged_low_y  = found ? mrg_lo[1] : '0;
                    r.merged_low_z  = found ? mrg_lo[2] : '0;
                    r.merged_high_x = found ? mrg_hi[0] : '0;
                    r.merged_high_y = found ? mrg_hi[1] : '0;
                    r.merged_high_z = found ? mrg_hi[2] : '0;
                    pending = {pending, r};
                    // The set-end box clears the merge once its result is formed.
                    if (w.mode == MODE_BOX_END) begin
                        sets++;
                        found = 1'b0;
                        for (int a = 0; a < NAXES; a++) begin
                            mrg_lo[a] = '0;
                            mrg_hi[a] = '0;
                        end
                    end
                end
                default: dropped++;
            endcase
        endfunction

        // Compares one result word with the oldest one still owed.
        task check_result(t_cull_result got);
            t_cull_result want;
            if (pending.size() == 0) begin
                report("result word arrived with nothing owed");
            end else begin
                want = pending.pop_front();
                check_field("box_visible", got.box_visible, want.box_visible);
                check_field("any_visible", got.any_visible, want.any_visible);
                check_field("set_done", got.set_done, want.set_done);
                check_field("merged_low_x", got.merged_low_x, want.merged_low_x);
                check_field("merged_low_y", got.merged_low_y, want.merged_low_y);
                check_field("merged_low_z", got.merged_low_z, want.merged_low_z);
                check_field("merged_high_x", got.merged_high_x, want.merged_high_x);
                check_field("merged_high_y", got.merged_high_y, want.merged_high_y);
                check_field("merged_high_z", got.merged_high_z, want.merged_high_z);
            end
            checked++;
        endtask
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [MODE_W-1:0]          i_mode;
    logic [PIDX_W-1:0]          i_plane_index;
    logic signed [NORM_W-1:0]   i_normal_x, i_normal_y, i_normal_z;
    logic signed [COORD_W-1:0]  i_plane_offset;
    logic signed [COORD_W-1:0]  i_low_x, i_low_y, i_low_z;
    logic signed [COORD_W-1:0]  i_high_x, i_high_y, i_high_z;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic                       o_box_visible, o_any_visible, o_set_done;
    logic signed [COORD_W-1:0]  o_merged_low_x, o_merged_low_y, o_merged_low_z;
    logic signed [COORD_W-1:0]  o_merged_high_x, o_merged_high_y, o_merged_high_z;

    cull_scoreboard board;
    int             coord_shift = 8;
    int             burst_left  = 0;
    int             words_sent  = 0;
    bit             hold_trigger = 1'b0;
    bit             hold_served  = 1'b0;
    int unsigned    cycle_count  = 0;

    aabb_frustum_cull_merge_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_plane_index   (i_plane_index),
        .i_normal_x      (i_normal_x),
        .i_normal_y      (i_normal_y),
        .i_normal_z      (i_normal_z),
        .i_plane_offset  (i_plane_offset),
        .i_low_x         (i_low_x),
        .i_low_y         (i_low_y),
        .i_low_z         (i_low_z),
        .i_high_x        (i_high_x),
        .i_high_y        (i_high_y),
        .i_high_z        (i_high_z),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_box_visible   (o_box_visible),
        .o_any_visible   (o_any_visible),
        .o_set_done      (o_set_done),
        .o_merged_low_x  (o_merged_low_x),
        .o_merged_low_y  (o_merged_low_y),
        .o_merged_low_z  (o_merged_low_z),
        .o_merged_high_x (o_merged_high_x),
        .o_merged_high_y (o_merged_high_y),
        .o_merged_high_z (o_merged_high_z)
    );

    // Free-running clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // A word of mode 3 with every other field random; callers overwrite what matters.
    function automatic t_cull_word noise_word();
        t_cull_word w;
        w.mode         = MODE_UNUSED;
        w.plane_index  = PIDX_W'($urandom);
        w.normal_x     = NORM_W'($urandom);
        w.normal_y     = NORM_W'($urandom);
        w.normal_z     = NORM_W'($urandom);
        w.plane_offset = $urandom;
        w.low_x        = $urandom;
        w.low_y        = $urandom;
        w.low_z        = $urandom;
        w.high_x       = $urandom;
        w.high_y       = $urandom;
        w.high_z       = $urandom;
        return w;
    endfunction

    function automatic t_cull_word plane_of(int idx, logic signed [NORM_W-1:0] nx,
                                            logic signed [NORM_W-1:0] ny,
                                            logic signed [NORM_W-1:0] nz,
                                            logic signed [COORD_W-1:0] off);
        t_cull_word w;
        w              = noise_word();
        w.mode         = MODE_LOAD;
        w.plane_index  = PIDX_W'(idx);
        w.normal_x     = nx;
        w.normal_y     = ny;
        w.normal_z     = nz;
        w.plane_offset = off;
        return w;
    endfunction

    function automatic t_cull_word box_of(logic [MODE_W-1:0] mode,
                                          logic signed [COORD_W-1:0] lx,
                                          logic signed [COORD_W-1:0] ly,
                                          logic signed [COORD_W-1:0] lz,
                                          logic signed [COORD_W-1:0] hx,
                                          logic signed [COORD_W-1:0] hy,
                                          logic signed [COORD_W-1:0] hz);
        t_cull_word w;
        w        = noise_word();
        w.mode   = mode;
        w.low_x  = lx;
        w.low_y  = ly;
        w.low_z  = lz;
        w.high_x = hx;
        w.high_y = hy;
        w.high_z = hz;
        return w;
    endfunction

    // Normal components lie between minus one and one half of the time, else are zero or fully random.
    function automatic logic signed [NORM_W-1:0] rnd_normal();
        case ($urandom_range(0, 7))
            0:       return '0;
            1, 2, 3: return NORM_W'($urandom);
            default: return NORM_W'(int'($urandom_range(0, 2 * ONE)) - ONE);
        endcase
    endfunction

    // Offsets sit a few box sizes behind the origin so that many boxes pass.
    function automatic logic signed [COORD_W-1:0] rnd_offset();
        int unsigned reach;
        reach = 1 << coord_shift;
        if ($urandom_range(0, 19) == 0) return $urandom;
        return -int'($urandom_range(reach, 6 * reach));
    endfunction

    // One axis of a box near the origin; now and then inverted or wild.
    function automatic void rnd_span(output logic signed [COORD_W-1:0] lo,
                                     output logic signed [COORD_W-1:0] hi);
        int unsigned reach;
        int          base;
        int          extent;
        reach  = 1 << coord_shift;
        base   = int'($urandom_range(0, 2 * reach)) - int'(reach);
        extent = int'($urandom_range(0, reach));
        lo     = base;
        hi     = base + extent;
        if ($urandom_range(0, 15) == 0) begin
            lo = $urandom;
            hi = $urandom;
        end else if ($urandom_range(0, 19) == 0) begin
            lo = base + extent;
            hi = base;
        end
    endfunction

    // Offers one word, often idling first when the current burst is used up.
    task automatic push_word(input t_cull_word w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_mode         <= w.mode;
        i_plane_index  <= w.plane_index;
        i_normal_x     <= w.normal_x;
        i_normal_y     <= w.normal_y;
        i_normal_z     <= w.normal_z;
        i_plane_offset <= w.plane_offset;
        i_low_x        <= w.low_x;
        i_low_y        <= w.low_y;
        i_low_z        <= w.low_z;
        i_high_x       <= w.high_x;
        i_high_y       <= w.high_y;
        i_high_z       <= w.high_z;
        do @(posedge i_clk); while (!o_in_ready);
        if (w.mode == MODE_BOX || w.mode == MODE_BOX_END ||
            (w.mode == MODE_LOAD && w.plane_index < NUM_PLANES))
            words_sent++;
    endtask

    // Loads a fresh frustum at a new scale, in forward or reverse slot order.
    task automatic load_frustum();
        bit reverse;
        coord_shift = $urandom_range(4, 27);
        reverse     = $urandom_range(0, 1);
        for (int p = 0; p < NUM_PLANES; p++)
            push_word(plane_of(reverse ? NUM_PLANES - 1 - p : p,
                               rnd_normal(), rnd_normal(), rnd_normal(), rnd_offset()));
    endtask

    // Watches both handshakes: results are checked, accepted words predicted.
    always @(posedge i_clk) begin
        t_cull_result got;
        t_cull_word   w;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.box_visible   = o_box_visible;
                got.any_visible   = o_any_visible;
                got.set_done      = o_set_done;
                got.merged_low_x  = o_merged_low_x;
                got.merged_low_y  = o_merged_low_y;
                got.merged_low_z  = o_merged_low_z;
                got.merged_high_x = o_merged_high_x;
                got.merged_high_y = o_merged_high_y;
                got.merged_high_z = o_merged_high_z;
                board.check_result(got);
            end
            if (i_in_valid && o_in_ready) begin
                w.mode         = i_mode;
                w.plane_index  = i_plane_index;
                w.normal_x     = i_normal_x;
                w.normal_y     = i_normal_y;
                w.normal_z     = i_normal_z;
                w.plane_offset = i_plane_offset;
                w.low_x        = i_low_x;
                w.low_y        = i_low_y;
                w.low_z        = i_low_z;
                w.high_x       = i_high_x;
                w.high_y       = i_high_y;
                w.high_z       = i_high_z;
                board.note_word(w);
            end
        end
    end

    // Result side: stretches of open, coin-flip, slow and periodic readiness,
    // plus one long hold-off that backs the block up into its input.
    initial begin : result_side
        t_rx_mode kind;
        int       stretch;
        int       tick;
        int       period;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_trigger && !hold_served) begin
                hold_served = 1'b1;
                i_out_ready <= 1'b0;
                for (tick = 0; tick < HOLD_CYCLES; tick++) @(posedge i_clk);
            end
            kind    = t_rx_mode'($urandom_range(0, 3));
            stretch = $urandom_range(10, 120);
            period  = $urandom_range(2, 6);
            for (tick = 0; tick < stretch; tick++) begin
                case (kind)
                    RX_OPEN: i_out_ready <= 1'b1;
                    RX_COIN: i_out_ready <= 1'($urandom_range(0, 1));
                    RX_SLOW: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ((tick % period) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Input side: reset, directed words, then the random run and the drain.
    initial begin : word_side
        logic signed [COORD_W-1:0] lx, ly, lz, hx, hy, hz;
        int                        pick;
        board = new();
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_mode         <= MODE_LOAD;
        i_plane_index  <= '0;
        i_normal_x     <= '0;
        i_normal_y     <= '0;
        i_normal_z     <= '0;
        i_plane_offset <= '0;
        i_low_x        <= '0;
        i_low_y        <= '0;
        i_low_z        <= '0;
        i_high_x       <= '0;
        i_high_y       <= '0;
        i_high_z       <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extreme normals and offsets in slot 0, pass-through planes elsewhere.
        push_word(plane_of(0, NORM_MAX, NORM_MIN, '0, COORD_MIN));
        for (int p = 1; p < NUM_PLANES - 1; p++) push_word(plane_of(p, '0, '0, '0, '0));
        push_word(plane_of(NUM_PLANES - 1, '0, '0, '0, COORD_MIN));
        // Loads beyond the last slot and mode 3 are dropped.
        push_word(plane_of(6, NORM_MIN, NORM_MAX, NORM_MAX, COORD_MAX));
        push_word(plane_of(7, rnd_normal(), rnd_normal(), rnd_normal(), $urandom));
        push_word(noise_word());
        // Widest box, the same box inverted, then a set end.
        push_word(box_of(MODE_BOX, COORD_MIN, COORD_MIN, COORD_MIN,
                         COORD_MAX, COORD_MAX, COORD_MAX));
        push_word(box_of(MODE_BOX, COORD_MAX, COORD_MAX, COORD_MAX,
                         COORD_MIN, COORD_MIN, COORD_MIN));
        push_word(box_of(MODE_BOX_END, '0, '0, '0, ONE, ONE, ONE));
        // A plane that culls everything: the set ends with zero bounds.
        push_word(plane_of(0, '0, '0, '0, 1));
        push_word(box_of(MODE_BOX_END, -ONE, -ONE, -ONE, ONE, ONE, ONE));
        // Sum exactly zero still passes, one step beyond is culled.
        push_word(plane_of(0, NORM_MAX, NORM_MAX, NORM_MAX, '0));
        push_word(box_of(MODE_BOX, -1, -1, -1, 7, 7, 7));
        push_word(box_of(MODE_BOX, '0, '0, '0, -3, 5, 9));
        push_word(box_of(MODE_BOX, 1, '0, '0, 10, 10, 10));
        push_word(box_of(MODE_BOX_END, -ONE, -2, -3, 2, 3, 4));
        // The merge restarts from the first visible box after a set end.
        push_word(box_of(MODE_BOX, -10, -10, -10, -5, -5, -5));

        // Random sets of boxes over occasionally reloaded frustums.
        load_frustum();
        while (words_sent < ITEM_TARGET) begin
            if (words_sent >= ITEM_TARGET / 2) hold_trigger = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                push_word(noise_word());
            end else if (pick < 5) begin
                push_word(plane_of($urandom_range(6, 7), rnd_normal(), rnd_normal(),
                                   rnd_normal(), $urandom));
            end else if (pick < 8) begin
                load_frustum();
            end else if (pick < 12) begin
                push_word(plane_of($urandom_range(0, NUM_PLANES - 1), rnd_normal(),
                                   rnd_normal(), rnd_normal(), rnd_offset()));
            end else begin
                rnd_span(lx, hx);
                rnd_span(ly, hy);
                rnd_span(lz, hz);
                push_word(box_of(($urandom_range(0, 4) == 0) ? MODE_BOX_END : MODE_BOX,
                                 lx, ly, lz, hx, hy, hz));
            end
        end
        i_in_valid <= 1'b0;

        // Drain: every owed result must arrive, and nothing after it. The bench waits
        // for the clock first, so that the last accepted word has been noted.
        @(posedge i_clk);
        while (board.waiting() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d box words (%0d visible) over %0d closed sets,",
                 board.boxes, board.visible, board.sets);
        $display("%0d plane loads and %0d dropped words; %0d results compared, %0d mismatches",
                 board.loads, board.dropped, board.checked, board.errors);
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> aabb_frustum_cull_merge_top.f
rtl/core/afcm_pkg.sv
rtl/core/afcm_mac.sv
rtl/core/aabb_frustum_cull_merge_top.sv
tb/tb_top.sv
